/* rtl/core/p2fr_pkg.sv */
// Shared types and constants for the P2 packet framer.
`default_nettype none
package p2fr_pkg;

  localparam int unsigned NUM_CHAN  = 6;
  localparam int unsigned NUM_STAGE = 4;

  // Fixed packet bytes
  localparam logic [7:0] SYNC0    = 8'hA5;
  localparam logic [7:0] SYNC1    = 8'h5A;
  localparam logic [7:0] VERSION  = 8'h02;
  localparam logic [7:0] SWITCHES = 8'h00;

  // Byte positions within the packet
  localparam logic [4:0] IDX_SYNC0    = 5'd0;
  localparam logic [4:0] IDX_SYNC1    = 5'd1;
  localparam logic [4:0] IDX_VERSION  = 5'd2;
  localparam logic [4:0] IDX_COUNT    = 5'd3;
  localparam logic [4:0] IDX_CH0      = 5'd4;
  localparam logic [4:0] IDX_SWITCHES = 5'd16;

  // Ramp: (8950 * t) / 255, done as multiply by ceil(2^31 / 255) then shift by 31
  localparam logic [13:0] RAMP_AMP   = 14'd8950;
  localparam logic [23:0] RAMP_RECIP = 24'd8421505;

  localparam logic signed [18:0] WORD_MAX = 19'sd32767;
  localparam logic signed [18:0] WORD_MIN = -19'sd32767;

  typedef logic [NUM_CHAN-1:0][15:0] words_t;

  typedef struct packed {
    logic [7:0] count;
    words_t     words;
  } pkt_t;

  // Load enables for the lane pipeline stages, stage 0 first
  typedef logic [NUM_STAGE-1:0] stage_en_t;

endpackage
`default_nettype wire

/* rtl/core/eeg_p2_packet_framer_top.sv */
// Top level of the P2 packet framer: input stream, six channel lanes, byte serializer.
// Pipeline: four lane stages (the first loads at the accepting edge), then the serializer
//   load; a stalled output can hold any stage. The first byte becomes valid once the
//   serializer has loaded the packet, and transfers when the output is free.
// Each frame is 17 packet bytes, one packet byte per output transfer; the single
//   byte-wide output port sets the frame rate, lanes and input run ahead.
// Reset (rst_ni low, asynchronous): pipeline and serializer empty, synthetic mode off.
`default_nettype none
module eeg_p2_packet_framer_top (
  input  wire           clk_i,
  input  wire           rst_ni,
  // Configuration: bit 0 is synthetic_mode
  input  wire           cfg_wr_en_i,
  input  wire           cfg_wr_data_i,
  // Frame input
  input  wire           s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata, low bit up: sample_count[7:0], chan_a[23:0], chan_b, chan_c,
  // chan_d, chan_e, chan_f (24 bits each)
  input  wire [151:0]   s_axis_tdata,
  // Packet byte output
  output logic          m_axis_tvalid,
  input  wire           m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [7:0]    m_axis_tdata,
  // tlast: is_last
  output logic          m_axis_tlast
);

  localparam int unsigned NS = p2fr_pkg::NUM_STAGE;

  logic                synth_q;
  logic [NS-1:0]       v_q, v_d;
  logic [NS-1:0]       stage_rdy;
  p2fr_pkg::stage_en_t load;
  logic [7:0]          cnt_q [NS];
  p2fr_pkg::words_t    words;
  p2fr_pkg::pkt_t      pkt;
  logic                pkt_ready;

  // Hold the mode bit; software must write it only while the block is idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synth_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      synth_q <= cfg_wr_data_i;
    end
  end

  // Lane pipeline control. A stage takes a new item when it is empty or its
  // item moves on in the same cycle; the last stage drains into the serializer.
  always_comb begin
    stage_rdy[NS-1] = !v_q[NS-1] || pkt_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      stage_rdy[i] = !v_q[i] || stage_rdy[i+1];
    end
    load[0] = stage_rdy[0] && s_axis_tvalid;
    for (int i = 1; i < NS; i++) begin
      load[i] = stage_rdy[i] && v_q[i-1];
    end
    v_d[NS-1] = load[NS-1] || (v_q[NS-1] && !pkt_ready);
    for (int i = 0; i < NS - 1; i++) begin
      v_d[i] = load[i] || (v_q[i] && !stage_rdy[i+1]);
    end
  end

  assign s_axis_tready = stage_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Carry the counter byte alongside the lanes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      if (load[i]) begin
        cnt_q[i] <= (i == 0) ? s_axis_tdata[7:0] : cnt_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // One lane per channel, channel g uses ramp multiplier g + 1
  for (genvar g = 0; g < p2fr_pkg::NUM_CHAN; g++) begin : g_lane
    p2fr_lane #(
      .ChanIdx(g + 1)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (load),
      .count_i (s_axis_tdata[7:0]),
      .sample_i(s_axis_tdata[8 + 24*g +: 24]),
      .synth_i (synth_q),
      .word_o  (words[g])
    );
  end

  assign pkt.count = cnt_q[NS-1];
  assign pkt.words = words;

  // Merge the lane words into the packet and send it byte by byte
  p2fr_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_valid_i(v_q[NS-1]),
    .pkt_ready_o(pkt_ready),
    .pkt_i      (pkt),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* rtl/core/p2fr_lane.sv */
// One channel lane: ramp generation, source select, scale by 1/32 and clamp.
`default_nettype none
module p2fr_lane #(
  parameter int unsigned ChanIdx = 1
) (
  input  wire                     clk_i,
  input  wire p2fr_pkg::stage_en_t en_i,
  input  wire logic [7:0]         count_i,
  input  wire logic [23:0]        sample_i,
  input  wire logic               synth_i,
  output logic [15:0]             word_o
);

  localparam logic [22:0] RAMP_AMP_W = 23'(p2fr_pkg::RAMP_AMP);

  logic [10:0]        cnt_mul;
  logic [9:0]         t_q;
  logic [23:0]        samp1_q, samp2_q;
  logic [22:0]        x_q;
  logic [46:0]        recip_prod;
  logic signed [23:0] val_q;
  logic signed [23:0] val_bias;
  logic signed [18:0] quot;
  logic [15:0]        word_d, word_q;

  // t = ((count * k) mod 256) + 512
  assign cnt_mul = 11'(count_i) * 11'(ChanIdx);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t_q     <= {2'b10, cnt_mul[7:0]};
      samp1_q <= sample_i;
    end
    if (en_i[1]) begin
      x_q     <= 23'(RAMP_AMP_W * t_q);
      samp2_q <= samp1_q;
    end
    if (en_i[2]) begin
      val_q <= synth_i ? $signed({9'd0, recip_prod[45:31]}) : $signed(samp2_q);
    end
    if (en_i[3]) begin
      word_q <= word_d;
    end
  end

  assign recip_prod = 47'(x_q) * 47'(p2fr_pkg::RAMP_RECIP);

  // Divide by 32 toward zero: bias negatives by 31 before the shift
  assign val_bias = val_q + (val_q[23] ? 24'sd31 : 24'sd0);
  assign quot     = val_bias[23:5];

  always_comb begin
    if (quot > p2fr_pkg::WORD_MAX) begin
      word_d = p2fr_pkg::WORD_MAX[15:0];
    end else if (quot < p2fr_pkg::WORD_MIN) begin
      word_d = p2fr_pkg::WORD_MIN[15:0];
    end else begin
      word_d = quot[15:0];
    end
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

/* rtl/core/p2fr_ser.sv */
// Merge stage: holds one finished packet and sends it one byte per transfer.
`default_nettype none
module p2fr_ser (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                pkt_valid_i,
  output logic               pkt_ready_o,
  input  wire p2fr_pkg::pkt_t pkt_i,
  output logic               m_valid_o,
  input  wire                m_ready_i,
  output logic [7:0]         m_data_o,
  output logic               m_last_o
);

  p2fr_pkg::pkt_t pkt_q;
  logic [4:0]     idx_q, idx_d;
  logic           busy_q, busy_d;
  logic           fire, last;
  logic [4:0]     woff;
  logic [2:0]     wsel;
  logic [15:0]    word;

  assign last        = (idx_q == p2fr_pkg::IDX_SWITCHES);
  assign fire        = busy_q && m_ready_i;
  assign pkt_ready_o = !busy_q || (fire && last);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pkt_ready_o && pkt_valid_i) begin
      busy_d = 1'b1;
      idx_d  = p2fr_pkg::IDX_SYNC0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= p2fr_pkg::IDX_SYNC0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_ready_o && pkt_valid_i) begin
      pkt_q <= pkt_i;
    end
  end

  // Channel words go out high byte first
  assign woff = idx_q - p2fr_pkg::IDX_CH0;
  assign wsel = woff[3:1];
  assign word = (wsel < 3'(p2fr_pkg::NUM_CHAN)) ? pkt_q.words[wsel] : 16'd0;

  always_comb begin
    unique case (idx_q)
      p2fr_pkg::IDX_SYNC0:    m_data_o = p2fr_pkg::SYNC0;
      p2fr_pkg::IDX_SYNC1:    m_data_o = p2fr_pkg::SYNC1;
      p2fr_pkg::IDX_VERSION:  m_data_o = p2fr_pkg::VERSION;
      p2fr_pkg::IDX_COUNT:    m_data_o = pkt_q.count;
      p2fr_pkg::IDX_SWITCHES: m_data_o = p2fr_pkg::SWITCHES;
      default:                m_data_o = woff[0] ? word[7:0] : word[15:8];
    endcase
  end

  assign m_valid_o = busy_q;
  assign m_last_o  = last;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= p2fr_pkg::IDX_SWITCHES)
    else $error("byte index past end of packet");

  a_load_starts_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_valid_i && pkt_ready_o) |=> (m_valid_o && m_data_o == p2fr_pkg::SYNC0))
    else $error("new packet does not start with sync byte");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && !pkt_valid_i) |=> !m_valid_o)
    else $error("output still valid after final byte with no packet pending");
`endif

endmodule
`default_nettype wire
